### rtl/core/fasp_pkg.sv
`timescale 1ns / 1ps
package fasp_pkg;

  // Default sizes of the block.
  localparam int FLOW_SLOTS_C = 1024;
  localparam int PRIO_BINS_C  = 8;
  localparam int FRAC_BITS_C  = 10;

  // Flow bookkeeping constants.
  localparam logic [47:0] DEFAULT_FLOW_SIZE = 48'd20000000;
  localparam logic [15:0] NO_PRIO_PORT      = 16'd9;
  localparam logic [47:0] BYTES_MAX         = '1;
  localparam int          FIN_BIT           = 0;
  localparam int          SYN_BIT           = 1;

  // Saturation limits of the reported score.
  localparam int SCORE_MAX = 4194303;
  localparam int SCORE_MIN = -4194304;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ALPHA     = 2'd0,
    CFG_PROFILE   = 2'd1,
    CFG_USE_PBS   = 2'd2,
    CFG_NON_BLIND = 2'd3
  } cfg_idx_t;

  // Flow entry after the read-modify-write stage.
  typedef struct packed {
    logic        valid;
    logic        bypass;
    logic        first;
    logic [63:0] now;
    logic [63:0] start;
    logic [47:0] bytes;
    logic [47:0] total;
  } upd_t;

  // Per-request control flags that travel beside the logarithm units.
  typedef struct packed {
    logic valid;
    logic zero_out;
    logic first;
    logic age_zero;
    logic op_zero;
  } flg_t;

  // Magnitude of -log2(limit) with 10 fraction bits, indexed by {profile, non_blind, bin}.
  localparam logic [18:0] LIMIT_MAG [128] = '{
    19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0,
    19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0,
    19'd63278, 19'd71435, 19'd79451, 19'd87495, 19'd95613, 19'd103687, 19'd111758, 19'd119863,
    19'd26482, 19'd62936, 19'd99383, 19'd135834, 19'd172280, 19'd208724, 19'd241772, 19'd281625,
    19'd65362, 19'd77639, 19'd89952, 19'd102255, 19'd114560, 19'd126856, 19'd139198, 19'd151502,
    19'd21879, 19'd58912, 19'd95929, 19'd132951, 19'd169983, 19'd206993, 19'd244018, 19'd318070,
    19'd68838, 19'd85506, 19'd102205, 19'd118917, 19'd135679, 19'd152380, 19'd169059, 19'd185737,
    19'd18333, 19'd55799, 19'd93266, 19'd130736, 19'd168199, 19'd205671, 19'd243138, 19'd277199,
    19'd70023, 19'd88174, 19'd106389, 19'd124568, 19'd142729, 19'd160932, 19'd179123, 19'd197296,
    19'd16296, 19'd54016, 19'd91745, 19'd126057, 19'd163779, 19'd201502, 19'd239225, 19'd276948,
    19'd71165, 19'd90377, 19'd109608, 19'd128875, 19'd148050, 19'd167317, 19'd186594, 19'd205783,
    19'd14719, 19'd52401, 19'd90081, 19'd127763, 19'd165444, 19'd203120, 19'd240805, 19'd278481,
    19'd66138, 19'd79202, 19'd92266, 19'd105330, 19'd118394, 19'd131459, 19'd144523, 19'd157587,
    19'd218217, 19'd220783, 19'd223349, 19'd225915, 19'd228482, 19'd231048, 19'd233614, 19'd236181,
    19'd71165, 19'd90377, 19'd109608, 19'd128875, 19'd148050, 19'd167317, 19'd186594, 19'd205783,
    19'd71165, 19'd90377, 19'd109608, 19'd128875, 19'd148050, 19'd167317, 19'd186594, 19'd205783
  };

endpackage

### rtl/core/flow_age_size_priority_classifier.sv
`timescale 1ns / 1ps
// Flow age/size priority classifier.
// Input requests arrive on s_tvalid/s_tready with the packet fields in s_tdata and the
// is_tcp and has_size_tag flags in s_tuser. Each request yields exactly one result on
// m_tvalid/m_tready carrying the priority bin and the saturated log2 score.
// Registers must be written via cfg_valid/cfg_ready/cfg_index/cfg_data only while no
// request is in flight, which the block does not enforce; cfg_ready is always high.
// The flow table is a single memory with a registered read at the accepting edge; the
// modify stage writes the updated entry back, and a back-to-back request to the same
// slot sees the written entry through a forwarding path.
// Throughput is one request per cycle while the output is not stalled. Results pass
// through the table stages and the two pipelined log2 units, which spend one squaring
// stage per fraction bit.
// After reset the table is swept clear, one entry a cycle, over all FLOW_SLOTS entries
// (1024 by default); s_tready stays low during the sweep.
// When the receiver holds m_tready low with a result waiting, the whole pipeline
// holds and s_tready drops in the same cycle.
module flow_age_size_priority_classifier import fasp_pkg::*; #(
  parameter int FLOW_SLOTS = FLOW_SLOTS_C,
  parameter int PRIO_BINS  = PRIO_BINS_C,
  parameter int FRAC_BITS  = FRAC_BITS_C
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // flow_slot, packet_bytes, now_ns, tcp_flags, source_port, flow_size
  input  logic [167:0] s_tdata,
  // is_tcp, has_size_tag
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // priority_res, score_log2
  output logic [31:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int LW = FRAC_BITS + 6;
  localparam int LL = FRAC_BITS + 2;

  logic [15:0] alpha;
  logic [2:0]  profile;
  logic        use_pbs;
  logic        non_blind;

  logic        adv;
  logic        busy;
  logic        in_bypass;
  logic [7:0]  flags;
  upd_t        upd;

  flg_t        eflg_next;
  logic [63:0] age_next;
  logic [47:0] op_next;
  logic [63:0] e_age;
  logic [63:0] e_op;
  flg_t        dly [LL+1];
  logic [LW-1:0] lg_age;
  logic [LW-1:0] lg_op;
  logic [2:0]  out_prio;
  logic [22:0] out_score;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv && !busy;
  assign cfg_ready = 1'b1;
  assign flags     = s_tdata[97:90];
  assign in_bypass = !s_tuser[0] || (flags[FIN_BIT] && flags[SYN_BIT]) ||
                     s_tdata[113:98] == NO_PRIO_PORT;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= 16'd1;
      profile   <= 3'd1;
      use_pbs   <= 1'b1;
      non_blind <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ALPHA:     alpha     <= cfg_data;
        CFG_PROFILE:   profile   <= cfg_data[2:0];
        CFG_USE_PBS:   use_pbs   <= cfg_data[0];
        CFG_NON_BLIND: non_blind <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fasp_table #(
    .FLOW_SLOTS(FLOW_SLOTS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_tvalid && s_tready),
    .in_slot   (s_tdata[9:0]),
    .in_pbytes (s_tdata[25:10]),
    .in_now    (s_tdata[89:26]),
    .in_bypass (in_bypass),
    .in_tag    (s_tuser[1]),
    .in_fsize  (s_tdata[161:114]),
    .non_blind (non_blind),
    .busy      (busy),
    .upd       (upd)
  );

  // Age and size operand of the updated flow.
  always_comb begin
    eflg_next.valid    = upd.valid;
    eflg_next.zero_out = upd.bypass || !use_pbs;
    eflg_next.first    = upd.first;
    eflg_next.age_zero = upd.now <= upd.start;
    eflg_next.op_zero  = !non_blind && upd.bytes == 48'd0;
    age_next = eflg_next.age_zero ? 64'd0 : upd.now - upd.start;
    if (non_blind) begin
      op_next = (upd.total > upd.bytes) ? upd.total - upd.bytes : 48'd1;
    end else begin
      op_next = upd.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_age <= age_next;
      e_op  <= 64'(op_next);
    end
  end

  // Flags travel beside the log2 units.
  always_ff @(posedge clk) begin
    if (rst) begin
      dly <= '{default: '0};
    end else if (adv) begin
      dly[0] <= eflg_next;
      for (int k = 0; k < LL; k++) begin
        dly[k+1] <= dly[k];
      end
    end
  end

  fasp_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_age (
    .clk (clk),
    .en  (adv),
    .x   (e_age),
    .lg  (lg_age)
  );

  fasp_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_op (
    .clk (clk),
    .en  (adv),
    .x   (e_op),
    .lg  (lg_op)
  );

  fasp_score #(
    .PRIO_BINS (PRIO_BINS),
    .FRAC_BITS (FRAC_BITS)
  ) u_score (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .fin       (dly[LL]),
    .lg_age    (lg_age),
    .lg_op     (lg_op),
    .alpha     (alpha),
    .profile   (profile),
    .non_blind (non_blind),
    .out_valid (m_tvalid),
    .out_prio  (out_prio),
    .out_score (out_score)
  );

  assign m_tdata = {6'd0, out_score, out_prio};

  // No request is taken while the table is being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("request accepted during table clear");

  // A nonzero priority only comes out with scoring enabled.
  a_prio_needs_pbs: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] != 3'd0) |-> use_pbs)
    else $error("nonzero priority with scoring disabled");

  // The priority never exceeds the top bin.
  a_prio_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= 3'(PRIO_BINS - 1)))
    else $error("priority beyond the top bin");

endmodule

### rtl/core/fasp_table.sv
`timescale 1ns / 1ps
module fasp_table import fasp_pkg::*; #(
  parameter int FLOW_SLOTS = FLOW_SLOTS_C
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [9:0]  in_slot,
  input  logic [15:0] in_pbytes,
  input  logic [63:0] in_now,
  input  logic        in_bypass,
  input  logic        in_tag,
  input  logic [47:0] in_fsize,
  input  logic        non_blind,
  output logic        busy,
  output upd_t        upd
);

  localparam int AW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;

  typedef struct packed {
    logic        valid;
    logic [63:0] start;
    logic [47:0] bytes;
    logic [47:0] total;
  } ent_t;

  // Reduce the slot modulo the table depth by conditional subtraction.
  function automatic logic [AW-1:0] slot_mod(input logic [9:0] s);
    int r;
    r = int'(s);
    for (int k = 9; k >= 0; k--) begin
      if ((FLOW_SLOTS << k) <= 1023 && r >= (FLOW_SLOTS << k)) begin
        r = r - (FLOW_SLOTS << k);
      end
    end
    return AW'(r);
  endfunction

  ent_t            mem [FLOW_SLOTS];
  ent_t            rd;
  logic            clearing;
  logic [AW-1:0]   clr_cnt;

  logic            m_valid;
  logic [AW-1:0]   m_slot;
  logic [15:0]     m_pbytes;
  logic [63:0]     m_now;
  logic            m_bypass;
  logic            m_tag;
  logic [47:0]     m_fsize;

  logic            fw_valid;
  logic [AW-1:0]   fw_slot;
  ent_t            fw_data;

  ent_t            ent;
  ent_t            ent_new;
  logic            first;
  logic [48:0]     bsum;
  logic            we_item;
  logic            we;
  logic [AW-1:0]   wa;
  ent_t            wd;

  assign busy = clearing;

  // Clearing pass over the table after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(FLOW_SLOTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Entry as seen by the request in the modify stage, with the write of the last edge forwarded.
  always_comb begin
    ent   = (fw_valid && fw_slot == m_slot) ? fw_data : rd;
    first = !ent.valid;
    bsum  = {1'b0, (first ? 48'd0 : ent.bytes)} + 49'(m_pbytes);
    ent_new.valid = 1'b1;
    ent_new.start = first ? m_now : ent.start;
    ent_new.bytes = bsum[48] ? BYTES_MAX : bsum[47:0];
    if (first) begin
      ent_new.total = (non_blind && m_tag) ? m_fsize : DEFAULT_FLOW_SIZE;
    end else begin
      ent_new.total = ent.total;
    end
    we_item = adv && m_valid && !m_bypass;
    we      = clearing || we_item;
    wa      = clearing ? clr_cnt : m_slot;
    wd      = clearing ? ent_t'('0) : ent_new;
  end

  // Flow table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (adv) begin
      rd <= mem[slot_mod(in_slot)];
    end
  end

  // Modify stage and forwarding record.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      fw_valid  <= 1'b0;
      upd.valid <= 1'b0;
    end else if (adv) begin
      m_valid   <= in_valid;
      fw_valid  <= we_item;
      upd.valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_slot     <= slot_mod(in_slot);
      m_pbytes   <= in_pbytes;
      m_now      <= in_now;
      m_bypass   <= in_bypass;
      m_tag      <= in_tag;
      m_fsize    <= in_fsize;
      fw_slot    <= m_slot;
      fw_data    <= ent_new;
      upd.bypass <= m_bypass;
      upd.first  <= first;
      upd.now    <= m_now;
      upd.start  <= ent_new.start;
      upd.bytes  <= ent_new.bytes;
      upd.total  <= ent_new.total;
    end
  end

endmodule

### rtl/core/fasp_log2.sv
`timescale 1ns / 1ps
module fasp_log2 import fasp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_C
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [63:0]           x,
  output logic [FRAC_BITS+5:0]  lg
);

  logic [63:0]          x1;
  logic [2:0]           ci1;
  logic [2:0]           ci;
  logic [7:0]           top_byte;
  logic [2:0]           fp;
  logic [5:0]           p;
  logic [63:0]          norm;
  logic [31:0]          ms [FRAC_BITS+1];
  logic [5:0]           ps [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] fs [FRAC_BITS+1];

  // Coarse search: highest nonzero byte.
  always_comb begin
    ci = '0;
    for (int i = 0; i < 8; i++) begin
      if (x[i*8 +: 8] != 8'd0) begin
        ci = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= x;
      ci1 <= ci;
    end
  end

  // Fine search inside that byte, then normalize the mantissa to 1.31.
  always_comb begin
    top_byte = x1[{ci1, 3'b000} +: 8];
    fp = '0;
    for (int i = 0; i < 8; i++) begin
      if (top_byte[i]) begin
        fp = 3'(i);
      end
    end
    p = {ci1, fp};
    if (p >= 6'd31) begin
      norm = x1 >> (p - 6'd31);
    end else begin
      norm = x1 << (6'd31 - p);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ms[0] <= norm[31:0];
      ps[0] <= p;
      fs[0] <= '0;
    end
  end

  // One squaring step per stage, one fraction bit each.
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(ms[k]) * 64'(ms[k]);
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (en) begin
        ms[k+1] <= t[32] ? t[32:1] : t[31:0];
        fs[k+1] <= {fs[k][FRAC_BITS-2:0], t[32]};
        ps[k+1] <= ps[k];
      end
    end
  end

  assign lg = {ps[FRAC_BITS], fs[FRAC_BITS]};

endmodule

### rtl/core/fasp_score.sv
`timescale 1ns / 1ps
module fasp_score import fasp_pkg::*; #(
  parameter int PRIO_BINS = PRIO_BINS_C,
  parameter int FRAC_BITS = FRAC_BITS_C
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  flg_t                 fin,
  input  logic [FRAC_BITS+5:0] lg_age,
  input  logic [FRAC_BITS+5:0] lg_op,
  input  logic [15:0]          alpha,
  input  logic [2:0]           profile,
  input  logic                 non_blind,
  output logic                 out_valid,
  output logic [2:0]           out_prio,
  output logic [22:0]          out_score
);

  localparam int LW  = FRAC_BITS + 6;
  localparam int SW  = (FRAC_BITS + 14 > 24) ? FRAC_BITS + 14 : 24;
  localparam int SHL = (FRAC_BITS >= 10) ? FRAC_BITS - 10 : 0;
  localparam int SHR = (FRAC_BITS < 10) ? 10 - FRAC_BITS : 0;
  localparam logic signed [SW-1:0] SMAX = SW'(SCORE_MAX);
  localparam logic signed [SW-1:0] SMIN = SW'(SCORE_MIN);

  logic [LW+15:0]          prod;
  flg_t                    a_flg;
  logic [LW-1:0]           a_lga;
  logic [LW+5:0]           a_term;
  flg_t                    s_flg;
  logic signed [SW-1:0]    s_score;
  logic [SW-1:0]           lim [PRIO_BINS];
  logic [2:0]              prio;
  logic signed [SW-1:0]    sat;
  logic [2:0]              prio_next;
  logic [22:0]             score_next;

  assign prod = (LW+16)'(alpha) * (LW+16)'(lg_op);

  // Alpha term, kept at zero when the operand is zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_flg <= '0;
      s_flg <= '0;
    end else if (en) begin
      a_flg <= fin;
      s_flg <= a_flg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lga   <= lg_age;
      a_term  <= fin.op_zero ? '0 : prod[LW+15:10];
      s_score <= $signed(SW'(a_lga)) - $signed(SW'(a_term));
    end
  end

  // Bin search against the selected limit set and final selection.
  always_comb begin
    prio = '0;
    for (int b = 0; b < PRIO_BINS; b++) begin
      lim[b] = -((SW'(LIMIT_MAG[{profile, non_blind, 3'(b)}]) << SHL) >> SHR);
      if (s_score <= $signed(lim[b])) begin
        prio = 3'(b);
      end
    end
    if (s_score > SMAX) begin
      sat = SMAX;
    end else if (s_score < SMIN) begin
      sat = SMIN;
    end else begin
      sat = s_score;
    end
    if (s_flg.zero_out) begin
      prio_next  = '0;
      score_next = '0;
    end else begin
      if (s_flg.age_zero) begin
        prio_next  = 3'(PRIO_BINS - 1);
        score_next = SMIN[22:0];
      end else if (s_flg.op_zero && alpha != 16'd0) begin
        prio_next  = '0;
        score_next = SMAX[22:0];
      end else begin
        prio_next  = prio;
        score_next = sat[22:0];
      end
      if (profile == 3'd0 || (s_flg.first && !non_blind)) begin
        prio_next = '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_flg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_prio  <= prio_next;
      out_score <= score_next;
    end
  end

endmodule

### tb/flow_classifier_checker.sv
`timescale 1ns / 1ps
module flow_classifier_checker import fasp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [167:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [31:0]  m_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [2:0]  prio;
    logic [22:0] score;
  } verdict_t;

  // -log2(limit) magnitudes, 10 fraction bits, by profile, mode and bin.
  localparam logic [18:0] BIN_LIMIT [8][2][8] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{'{63278, 71435, 79451, 87495, 95613, 103687, 111758, 119863},
      '{26482, 62936, 99383, 135834, 172280, 208724, 241772, 281625}},
    '{'{65362, 77639, 89952, 102255, 114560, 126856, 139198, 151502},
      '{21879, 58912, 95929, 132951, 169983, 206993, 244018, 318070}},
    '{'{68838, 85506, 102205, 118917, 135679, 152380, 169059, 185737},
      '{18333, 55799, 93266, 130736, 168199, 205671, 243138, 277199}},
    '{'{70023, 88174, 106389, 124568, 142729, 160932, 179123, 197296},
      '{16296, 54016, 91745, 126057, 163779, 201502, 239225, 276948}},
    '{'{71165, 90377, 109608, 128875, 148050, 167317, 186594, 205783},
      '{14719, 52401, 90081, 127763, 165444, 203120, 240805, 278481}},
    '{'{66138, 79202, 92266, 105330, 118394, 131459, 144523, 157587},
      '{218217, 220783, 223349, 225915, 228482, 231048, 233614, 236181}},
    '{'{71165, 90377, 109608, 128875, 148050, 167317, 186594, 205783},
      '{71165, 90377, 109608, 128875, 148050, 167317, 186594, 205783}}
  };

  // Register copies.
  logic [15:0] alpha;
  logic [2:0]  prof;
  logic        pbs_on;
  logic        nb_mode;

  // Flow table copy.
  logic        flow_live  [1024];
  logic [63:0] flow_start [1024];
  logic [47:0] flow_bytes [1024];
  logic [47:0] flow_total [1024];

  verdict_t expected_q[$];

  // Base-2 logarithm with 10 fraction bits, truncated.
  function automatic logic [63:0] log2_q10(input logic [63:0] x);
    int p;
    int i;
    logic [63:0] m;
    logic [63:0] frac;
    p = 63;
    while (p > 0 && !x[p]) p--;
    if (p >= 31) m = x >> (p - 31);
    else m = x << (31 - p);
    frac = '0;
    for (i = 0; i < 10; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(p) << 10) | frac;
  endfunction

  // Updates the flow entry and works out the priority and score of one request.
  function automatic verdict_t classify(input logic [167:0] d, input logic [1:0] u);
    logic [9:0]  slot;
    logic [63:0] now;
    logic [7:0]  flags;
    logic [15:0] port;
    logic [47:0] fsize;
    logic [48:0] sum;
    logic [63:0] age;
    logic [63:0] operand;
    logic [63:0] term;
    longint      score;
    logic [2:0]  prio;
    logic        first;
    verdict_t    v;
    slot  = d[9:0];
    now   = d[89:26];
    flags = d[97:90];
    port  = d[113:98];
    fsize = d[161:114];
    v = '0;
    first = 1'b0;
    if (!u[0] || (flags[FIN_BIT] && flags[SYN_BIT]) || port == NO_PRIO_PORT) return v;
    if (!flow_live[slot]) begin
      flow_live[slot]  = 1'b1;
      flow_start[slot] = now;
      flow_bytes[slot] = '0;
      flow_total[slot] = (nb_mode && u[1]) ? fsize : DEFAULT_FLOW_SIZE;
      first = 1'b1;
    end
    sum = {1'b0, flow_bytes[slot]} + 49'(d[25:10]);
    flow_bytes[slot] = sum[48] ? BYTES_MAX : sum[47:0];
    if (!pbs_on) return v;
    age = (now >= flow_start[slot]) ? now - flow_start[slot] : 64'd0;
    if (nb_mode)
      operand = (flow_total[slot] > flow_bytes[slot]) ?
                64'(flow_total[slot] - flow_bytes[slot]) : 64'd1;
    else
      operand = 64'(flow_bytes[slot]);
    prio = '0;
    if (age == 0) begin
      score = SCORE_MIN;
      prio = 3'd7;
    end else if (operand == 0 && alpha != 0) begin
      score = SCORE_MAX;
    end else begin
      term = (operand != 0) ? (64'(alpha) * log2_q10(operand)) >> 10 : 64'd0;
      score = longint'(log2_q10(age)) - longint'(term);
      if (prof != 0) begin
        for (int b = 7; b >= 0; b--) begin
          if (score <= -longint'(BIN_LIMIT[prof][nb_mode][b])) begin
            prio = 3'(b);
            break;
          end
        end
      end
      if (score > SCORE_MAX) score = SCORE_MAX;
      if (score < SCORE_MIN) score = SCORE_MIN;
    end
    if (prof == 0 || (first && !nb_mode)) prio = '0;
    v.prio  = prio;
    v.score = score[22:0];
    return v;
  endfunction

  task automatic report(input string what, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    errors++;
  endtask

  // Watch the three channels at each rising edge.
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      alpha   <= 16'd1;
      prof    <= 3'd1;
      pbs_on  <= 1'b1;
      nb_mode <= 1'b0;
      for (int i = 0; i < 1024; i++) flow_live[i] = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ALPHA:     alpha   <= cfg_data;
          CFG_PROFILE:   prof    <= cfg_data[2:0];
          CFG_USE_PBS:   pbs_on  <= cfg_data[0];
          CFG_NON_BLIND: nb_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_q.insert(expected_q.size(), classify(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 0, 1);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[2:0] !== want.prio) report("priority_res", want.prio, m_tdata[2:0]);
          if (m_tdata[25:3] !== want.score)
            report("score_log2", $signed(want.score), $signed(m_tdata[25:3]));
        end
      end
    end
    pending <= expected_q.size();
  end

  initial errors = 0;

endmodule

### tb/tb_flow_age_size_priority_classifier.sv
`timescale 1ns / 1ps
module tb_flow_age_size_priority_classifier import fasp_pkg::*;;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // flow_slot, packet_bytes, now_ns, tcp_flags, source_port, flow_size
  logic [167:0] s_tdata;
  // is_tcp, has_size_tag
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  // priority_res, score_log2
  logic [31:0]  m_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;
  int           errors;
  int           pending;

  logic         hold_req;
  logic         no_gaps;
  logic [63:0]  clock_ns;

  flow_age_size_priority_classifier i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  flow_classifier_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Overall time limit.
  initial begin
    #5ms;
    $display("tb_flow_age_size_priority_classifier NOT OK");
    $finish;
  end

  // Result receiver: random stalls and a single long hold-off when hold_req is set.
  initial begin
    int k;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      k = no_gaps ? 0 : int'($urandom_range(0, 3));
      if (k > 0) begin
        m_tready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Offer one request and wait until it is taken.
  task automatic send_pkt(input logic [9:0] slot, input logic [15:0] nbytes,
                          input logic [63:0] now, input logic tcp, input logic [7:0] flags,
                          input logic [15:0] port, input logic has_tag,
                          input logic [47:0] fsize);
    int k;
    @(negedge clk);
    k = no_gaps ? 0 : int'($urandom_range(0, 3));
    if (k > 0) begin
      s_tvalid <= 1'b0;
      repeat (k) @(negedge clk);
    end
    s_tdata  <= {6'd0, fsize, port, flags, now, nbytes, slot};
    s_tuser  <= {has_tag, tcp};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Lower valid and wait until every result is back and the pipeline has drained.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Mostly well-formed TCP packets on a small set of flows; the rest is noise.
  task automatic random_pkt();
    logic [9:0]  slot;
    logic [7:0]  flags;
    logic [15:0] port;
    logic [47:0] fsize;
    logic [63:0] now;
    clock_ns = clock_ns + 64'($urandom_range(0, 20000));
    now = clock_ns;
    if ($urandom_range(0, 19) == 0) now = {$urandom, $urandom};
    else if ($urandom_range(0, 19) == 0) now = clock_ns - 64'($urandom_range(0, 50000));
    fsize = ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom}) :
                                          48'($urandom_range(0, 300000));
    if ($urandom_range(0, 99) < 85) begin
      slot = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 47));
      flags = 8'($urandom);
      if (flags[FIN_BIT] && flags[SYN_BIT]) flags[FIN_BIT] = 1'b0;
      port = 16'($urandom);
      if (port == NO_PRIO_PORT) port = 16'd80;
      send_pkt(slot, 16'($urandom_range(0, 1500)), now, 1'b1, flags, port,
               1'($urandom), fsize);
    end else begin
      port = ($urandom_range(0, 3) == 0) ? NO_PRIO_PORT : 16'($urandom);
      send_pkt(10'($urandom), 16'($urandom), now, 1'($urandom), 8'($urandom), port,
               1'($urandom), fsize);
    end
  endtask

  initial begin
    logic [15:0] alphas [8] = '{16'd1, 16'd1024, 16'd0, 16'd65535, 16'd512, 16'd1024,
                                16'd2048, 16'd768};
    logic [2:0]  profs  [8] = '{3'd1, 3'd3, 3'd7, 3'd2, 3'd0, 3'd6, 3'd4, 3'd5};
    logic        pbss   [8] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    logic        nbs    [8] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ALPHA;
    cfg_data  = '0;
    hold_req  = 1'b0;
    no_gaps   = 1'b0;
    clock_ns  = 64'd1000000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_ALPHA, alphas[ph]);
      write_reg(CFG_PROFILE, 16'(profs[ph]));
      write_reg(CFG_USE_PBS, 16'(pbss[ph]));
      write_reg(CFG_NON_BLIND, 16'(nbs[ph]));
      no_gaps = (ph == 2 || ph == 6);

      if (ph == 0) begin
        // Bypassed packets: not TCP, SYN with FIN, and the no-priority port.
        send_pkt(10'd1, 16'd100, 64'd500, 1'b0, 8'h10, 16'd80, 1'b0, 48'd0);
        send_pkt(10'd1, 16'd100, 64'd500, 1'b1, 8'h03, 16'd80, 1'b0, 48'd0);
        send_pkt(10'd1, 16'd100, 64'd500, 1'b1, 8'h10, NO_PRIO_PORT, 1'b0, 48'd0);
        // First packet with no bytes, then zero age, zero bytes, time going back.
        send_pkt(10'd5, 16'd0, 64'd1000, 1'b1, 8'h02, 16'd1234, 1'b0, 48'd0);
        send_pkt(10'd5, 16'd0, 64'd1000, 1'b1, 8'h10, 16'd1234, 1'b0, 48'd0);
        send_pkt(10'd5, 16'd0, 64'd5000, 1'b1, 8'h10, 16'd1234, 1'b0, 48'd0);
        send_pkt(10'd5, 16'd40, 64'd100, 1'b1, 8'h10, 16'd1234, 1'b0, 48'd0);
        send_pkt(10'd5, 16'd1460, 64'd90000, 1'b1, 8'h10, 16'd1234, 1'b0, 48'd0);
        // Field extremes.
        send_pkt(10'd1023, 16'hFFFF, 64'd0, 1'b1, 8'hFC, 16'hFFFF, 1'b1, '1);
        send_pkt(10'd1023, 16'hFFFF, '1, 1'b1, 8'hFD, 16'hFFFF, 1'b1, '1);
        send_pkt(10'd0, 16'd1, 64'd7, 1'b1, 8'h00, 16'd0, 1'b0, 48'd0);
        send_pkt(10'd0, 16'd1, 64'h8000_0000_0000_0000, 1'b1, 8'h01, 16'd0, 1'b0, 48'd0);
      end else if (ph == 3) begin
        // Tagged small flow overrun gives remaining bytes of one.
        send_pkt(10'd700, 16'd100, 64'd2000, 1'b1, 8'h02, 16'd443, 1'b1, 48'd150);
        send_pkt(10'd700, 16'd100, 64'd9000, 1'b1, 8'h10, 16'd443, 1'b1, 48'd0);
        // Huge tagged size keeps all 48 bits of the remaining count.
        send_pkt(10'd701, 16'd10, 64'd2000, 1'b1, 8'h02, 16'd443, 1'b1, '1);
        send_pkt(10'd701, 16'd10, 64'd8000000, 1'b1, 8'h10, 16'd443, 1'b1, 48'd0);
        // Untagged flow takes the default size.
        send_pkt(10'd702, 16'd1000, 64'd3000, 1'b1, 8'h02, 16'd443, 1'b0, 48'd5);
        send_pkt(10'd702, 16'd1000, 64'd700000, 1'b1, 8'h10, 16'd443, 1'b0, 48'd5);
      end

      for (int n = 0; n < 175; n++) begin
        if (ph == 4 && n == 40) hold_req = 1'b1;
        random_pkt();
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_flow_age_size_priority_classifier OK");
    end else begin
      $display("tb_flow_age_size_priority_classifier NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/fasp_pkg.sv
rtl/core/fasp_table.sv
rtl/core/fasp_log2.sv
rtl/core/fasp_score.sv
rtl/core/flow_age_size_priority_classifier.sv
tb/flow_classifier_checker.sv
tb/tb_flow_age_size_priority_classifier.sv
